// ----- src/pwaf_pkg.sv -----
`timescale 1ns / 1ps

package pwaf_pkg;

    localparam int HISTORY_DAYS_DEF = 30;
    localparam int ZONE_COUNT_DEF   = 16;

    localparam int SAMPLE_W   = 16;
    localparam int SCALE_W    = 46;
    localparam int SCALE_LO_W = 23;
    localparam int MUL_W      = 32;
    localparam int PROD_W     = 64;
    localparam int FC_W       = 17;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [CFG_IDX_W-1:0] REG_PM25_LIMIT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NO2_LIMIT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SO2_LIMIT  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CO2_LIMIT  = 2'd3;

    localparam logic [12:0] PM25_LIMIT_RST = 13'd150;
    localparam logic [12:0] NO2_LIMIT_RST  = 13'd250;
    localparam logic [12:0] SO2_LIMIT_RST  = 13'd400;
    localparam logic [15:0] CO2_LIMIT_RST  = 16'd10000;

    localparam logic [15:0] Q_ONE  = 16'd32768;
    localparam logic [15:0] T_COLD = 16'd39321;
    localparam logic [15:0] T_WARM = 16'd29491;
    localparam logic signed [10:0] TEMP_COLD_EDGE = 11'sd100;
    localparam logic signed [10:0] TEMP_WARM_EDGE = 11'sd200;
    localparam logic [10:0] WIND_CLAMP = 11'd1000;
    localparam logic [9:0]  HUM_CLAMP  = 10'd1000;
    localparam logic [22:0] WIND_NUM   = 23'd6144;
    localparam logic [22:0] HUM_NUM    = 23'd3072;
    // Exact reciprocal of 625 for numerators below 2^23.
    localparam logic [31:0] RECIP_625   = 32'd13743896;
    localparam int          RECIP_SHIFT = 33;

    localparam logic [FC_W-1:0] FC_MAX_SMALL = 17'h01FFF;
    localparam logic [FC_W-1:0] FC_MAX_CO2   = 17'h1FFFF;

    typedef struct packed {
        logic [12:0] pm25_limit;
        logic [12:0] no2_limit;
        logic [12:0] so2_limit;
        logic [15:0] co2_high_limit;
    } cfg_t;

    typedef struct packed {
        logic [1:0]                   level;
        logic [3:0]                   zone;
        logic [3:0][SAMPLE_W-1:0]     sample;
        logic [SCALE_W-1:0]           scale;
    } item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    typedef enum logic [2:0] {
        F_IDLE, F_WIND, F_HUM, F_MIX, F_TEMP, F_PUSH
    } front_state_t;

    typedef enum logic [2:0] {
        B_IDLE, B_READ, B_UPD, B_DIV, B_LO, B_HI, B_FIN, B_OUT
    } back_state_t;

    function automatic logic [1:0] level_of(input logic [15:0] v, input logic [15:0] lim);
        logic [17:0] v2;
        logic [17:0] l3;
        logic [17:0] l2;
        logic [1:0]  lvl;
        v2 = {1'b0, v, 1'b0};
        l2 = {1'b0, lim, 1'b0};
        l3 = l2 + 18'(lim);
        if (lim == 16'd0 || v <= lim)
            lvl = 2'd0;
        else if (v2 <= l3)
            lvl = 2'd1;
        else if (18'(v) <= l2)
            lvl = 2'd2;
        else
            lvl = 2'd3;
        return lvl;
    endfunction

endpackage

// ----- src/pwaf_front.sv -----
`timescale 1ns / 1ps

module pwaf_front (
    input  logic                    clk,
    input  logic                    rst_n,
    input  pwaf_pkg::cfg_t          cfg,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [3:0]              zone,
    input  logic [12:0]             pm25_sample,
    input  logic [12:0]             no2_sample,
    input  logic [12:0]             so2_sample,
    input  logic [15:0]             co2_sample,
    input  logic signed [10:0]      air_temperature,
    input  logic [10:0]             wind_speed,
    input  logic [9:0]              relative_humidity,
    input  pwaf_pkg::queue_status_t q_status,
    output logic                    push,
    output pwaf_pkg::item_t         push_item
);
    import pwaf_pkg::*;

    front_state_t        state_reg, state_next;
    item_t               item_reg;
    logic signed [10:0]  temp_reg;
    logic [9:0]          wind_reg;
    logic [9:0]          hum_reg;
    logic [15:0]         fw_reg;
    logic [PROD_W-1:0]   prod_reg;
    logic                mul_en;
    logic [MUL_W-1:0]    mul_a, mul_b;
    logic [15:0]         fh;
    logic [15:0]         ft;
    logic [1:0]          lvl_pm, lvl_no, lvl_so, lvl_max, lvl_in;

    always_comb
    begin
        lvl_pm  = level_of(16'(pm25_sample), 16'(cfg.pm25_limit));
        lvl_no  = level_of(16'(no2_sample), 16'(cfg.no2_limit));
        lvl_so  = level_of(16'(so2_sample), 16'(cfg.so2_limit));
        lvl_max = (lvl_pm > lvl_no) ? lvl_pm : lvl_no;
        lvl_max = (lvl_so > lvl_max) ? lvl_so : lvl_max;
        lvl_in  = (co2_sample > cfg.co2_high_limit && lvl_max == 2'd0) ? 2'd1 : lvl_max;
    end

    always_comb
    begin
        fh = Q_ONE + 16'(prod_reg >> RECIP_SHIFT);
        if (temp_reg < TEMP_COLD_EDGE)
            ft = T_COLD;
        else if (temp_reg > TEMP_WARM_EDGE)
            ft = T_WARM;
        else
            ft = Q_ONE;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            F_IDLE: if (in_valid) state_next = F_WIND;
            F_WIND: state_next = F_HUM;
            F_HUM:  state_next = F_MIX;
            F_MIX:  state_next = F_TEMP;
            F_TEMP: state_next = F_PUSH;
            F_PUSH: if (!q_status.full) state_next = F_IDLE;
            default: state_next = F_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready = 1'b0;
        push     = 1'b0;
        mul_en   = 1'b0;
        mul_a    = '0;
        mul_b    = '0;
        case (state_reg)
            F_IDLE: in_ready = 1'b1;
            F_WIND:
            begin
                mul_en = 1'b1;
                mul_a  = 32'(23'(wind_reg) * WIND_NUM);
                mul_b  = RECIP_625;
            end
            F_HUM:
            begin
                mul_en = 1'b1;
                mul_a  = 32'(23'(hum_reg) * HUM_NUM);
                mul_b  = RECIP_625;
            end
            F_MIX:
            begin
                mul_en = 1'b1;
                mul_a  = 32'(fw_reg);
                mul_b  = 32'(fh);
            end
            F_TEMP:
            begin
                mul_en = 1'b1;
                mul_a  = prod_reg[MUL_W-1:0];
                mul_b  = 32'(ft);
            end
            F_PUSH: push = !q_status.full;
            default: ;
        endcase
    end

    always_comb
    begin
        push_item       = item_reg;
        push_item.scale = prod_reg[SCALE_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= F_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_reg.level     <= lvl_in;
            item_reg.zone      <= zone;
            item_reg.sample[0] <= 16'(pm25_sample);
            item_reg.sample[1] <= 16'(no2_sample);
            item_reg.sample[2] <= 16'(so2_sample);
            item_reg.sample[3] <= co2_sample;
            item_reg.scale     <= '0;
            temp_reg           <= air_temperature;
            wind_reg           <= (wind_speed > WIND_CLAMP) ? 10'(WIND_CLAMP) : wind_speed[9:0];
            hum_reg            <= (relative_humidity > HUM_CLAMP) ? HUM_CLAMP : relative_humidity;
        end
        if (state_reg == F_HUM)
            fw_reg <= Q_ONE - 16'(prod_reg >> RECIP_SHIFT);
        if (mul_en)
            prod_reg <= 64'(mul_a) * 64'(mul_b);
    end

endmodule

// ----- src/pwaf_queue.sv -----
`timescale 1ns / 1ps

module pwaf_queue (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  pwaf_pkg::item_t         push_item,
    input  logic                    pop,
    output pwaf_pkg::item_t         head_item,
    output pwaf_pkg::queue_status_t status
);
    import pwaf_pkg::*;

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    item_t           entry_reg [QUEUE_DEPTH];
    logic [PW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]   count_reg;

    assign head_item    = entry_reg[rd_ptr_reg];
    assign status.full  = (count_reg == CW'(QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_item;
    end

endmodule

// ----- src/pwaf_back.sv -----
`timescale 1ns / 1ps

module pwaf_back #(
    parameter int HISTORY_DAYS = pwaf_pkg::HISTORY_DAYS_DEF,
    parameter int ZONE_COUNT   = pwaf_pkg::ZONE_COUNT_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  pwaf_pkg::queue_status_t    q_status,
    input  pwaf_pkg::item_t            head_item,
    output logic                       pop,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [1:0]                 alert_level,
    output logic [12:0]                pm25_forecast,
    output logic [12:0]                no2_forecast,
    output logic [12:0]                so2_forecast,
    output logic [pwaf_pkg::FC_W-1:0]  co2_forecast
);
    import pwaf_pkg::*;

    localparam longint WEIGHT_TOTAL = longint'(HISTORY_DAYS) * (HISTORY_DAYS + 1) / 2;
    localparam int     WS_W  = $clog2(WEIGHT_TOTAL * 65535 + 1);
    localparam int     PS_W  = $clog2(longint'(HISTORY_DAYS) * 65535 + 1);
    localparam int     DIV_S = WS_W + $clog2(WEIGHT_TOTAL);
    localparam longint DIV_M = ((longint'(1) << DIV_S) + WEIGHT_TOTAL - 1) / WEIGHT_TOTAL;
    localparam int     HW    = $clog2(HISTORY_DAYS);
    localparam int     ZW    = (ZONE_COUNT > 1) ? $clog2(ZONE_COUNT) : 1;
    localparam int     DEPTH = ZONE_COUNT * HISTORY_DAYS;
    localparam int     AW    = $clog2(DEPTH);
    localparam int     WIN_W = 3 * 13 + 16;

    back_state_t              state_reg, state_next;
    item_t                    item_reg;
    logic [1:0]               pol_reg;
    logic [HW-1:0]            head_reg [ZONE_COUNT];
    logic                     full_reg [ZONE_COUNT];
    logic [WIN_W-1:0]         win_mem  [DEPTH];
    logic [3:0][PS_W-1:0]     ps_mem   [ZONE_COUNT];
    logic [3:0][WS_W-1:0]     ws_mem   [ZONE_COUNT];
    logic [WIN_W-1:0]         win_rd_reg;
    logic [3:0][PS_W-1:0]     ps_rd_reg;
    logic [3:0][WS_W-1:0]     ws_rd_reg;
    logic                     seen_reg, full_cur_reg;
    logic [3:0][WS_W-1:0]     ws_reg;
    logic [PROD_W-1:0]        prod_reg;
    logic [15:0]              avg_reg;
    logic [38:0]              lo_reg;
    logic [3:0][FC_W-1:0]     fc_reg;
    logic                     out_valid_reg;
    logic [1:0]               out_level_reg;
    logic [3:0][FC_W-1:0]     out_fc_reg;

    logic                     in_range;
    logic [ZW-1:0]            zidx;
    logic [HW-1:0]            head_cur;
    logic [AW-1:0]            addr;
    logic [3:0][15:0]         oldest;
    logic [3:0][PS_W-1:0]     ps_new;
    logic [3:0][WS_W-1:0]     ws_new;
    logic [WIN_W-1:0]         win_wr;
    logic                     mul_en, load_out;
    logic [MUL_W-1:0]         mul_a, mul_b;
    logic [15:0]              avg;
    logic [39:0]              acc;
    logic [FC_W:0]            res;
    logic [FC_W-1:0]          res_max;

    always_comb
    begin
        in_range = (int'(item_reg.zone) < ZONE_COUNT);
        zidx     = ZW'(item_reg.zone);
        head_cur = head_reg[zidx];
        addr     = AW'(int'(zidx) * HISTORY_DAYS + int'(head_cur));
        win_wr   = {item_reg.sample[3], item_reg.sample[2][12:0],
                    item_reg.sample[1][12:0], item_reg.sample[0][12:0]};
        oldest[0] = 16'(win_rd_reg[12:0]);
        oldest[1] = 16'(win_rd_reg[25:13]);
        oldest[2] = 16'(win_rd_reg[38:26]);
        oldest[3] = win_rd_reg[54:39];
        for (int p = 0; p < 4; p++)
        begin
            if (!full_cur_reg)
                oldest[p] = '0;
            ps_new[p] = (seen_reg ? ps_rd_reg[p] : '0) - PS_W'(oldest[p])
                        + PS_W'(item_reg.sample[p]);
            ws_new[p] = (seen_reg ? ws_rd_reg[p] : '0) - WS_W'(seen_reg ? ps_rd_reg[p] : '0)
                        + WS_W'(item_reg.sample[p]) * WS_W'(HISTORY_DAYS);
        end
    end

    always_comb
    begin
        avg     = prod_reg[DIV_S +: 16];
        acc     = prod_reg[39:0] + 40'(lo_reg[38:23]);
        res     = acc[39:22];
        res_max = (pol_reg == 2'd3) ? FC_MAX_CO2 : FC_MAX_SMALL;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE: if (!q_status.empty) state_next = B_READ;
            B_READ: state_next = in_range ? B_UPD : B_OUT;
            B_UPD:  state_next = B_DIV;
            B_DIV:  state_next = B_LO;
            B_LO:   state_next = B_HI;
            B_HI:   state_next = B_FIN;
            B_FIN:  state_next = (pol_reg == 2'd3) ? B_OUT : B_DIV;
            B_OUT:  if (!out_valid_reg || out_ready) state_next = B_IDLE;
            default: state_next = B_IDLE;
        endcase
    end

    always_comb
    begin
        pop      = 1'b0;
        load_out = 1'b0;
        mul_en   = 1'b0;
        mul_a    = '0;
        mul_b    = '0;
        case (state_reg)
            B_IDLE: pop = !q_status.empty;
            B_DIV:
            begin
                mul_en = 1'b1;
                mul_a  = 32'(ws_reg[pol_reg]);
                mul_b  = 32'(DIV_M);
            end
            B_LO:
            begin
                mul_en = 1'b1;
                mul_a  = 32'(avg);
                mul_b  = 32'(item_reg.scale[SCALE_LO_W-1:0]);
            end
            B_HI:
            begin
                mul_en = 1'b1;
                mul_a  = 32'(avg_reg);
                mul_b  = 32'(item_reg.scale[SCALE_W-1:SCALE_LO_W]);
            end
            B_OUT: load_out = !out_valid_reg || out_ready;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            pol_reg       <= '0;
            out_valid_reg <= 1'b0;
            for (int z = 0; z < ZONE_COUNT; z++)
            begin
                head_reg[z] <= '0;
                full_reg[z] <= 1'b0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == B_UPD)
            begin
                pol_reg <= '0;
                if (head_cur == HW'(HISTORY_DAYS - 1))
                begin
                    head_reg[zidx] <= '0;
                    full_reg[zidx] <= 1'b1;
                end
                else
                    head_reg[zidx] <= head_cur + 1'b1;
            end
            else if (state_reg == B_FIN)
                pol_reg <= pol_reg + 1'b1;
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            item_reg <= head_item;
        if (state_reg == B_READ)
        begin
            win_rd_reg   <= win_mem[addr];
            ps_rd_reg    <= ps_mem[zidx];
            ws_rd_reg    <= ws_mem[zidx];
            full_cur_reg <= full_reg[zidx];
            seen_reg     <= full_reg[zidx] || (head_cur != '0);
            if (!in_range)
                fc_reg <= '0;
        end
        if (state_reg == B_UPD)
        begin
            win_mem[addr] <= win_wr;
            ps_mem[zidx]  <= ps_new;
            ws_mem[zidx]  <= ws_new;
            ws_reg        <= ws_new;
        end
        if (mul_en)
            prod_reg <= 64'(mul_a) * 64'(mul_b);
        if (state_reg == B_LO)
            avg_reg <= avg;
        if (state_reg == B_HI)
            lo_reg <= prod_reg[38:0];
        if (state_reg == B_FIN)
            fc_reg[pol_reg] <= (res > (FC_W + 1)'(res_max)) ? res_max : res[FC_W-1:0];
        if (load_out)
        begin
            out_level_reg <= item_reg.level;
            out_fc_reg    <= fc_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign alert_level   = out_level_reg;
    assign pm25_forecast = out_fc_reg[0][12:0];
    assign no2_forecast  = out_fc_reg[1][12:0];
    assign so2_forecast  = out_fc_reg[2][12:0];
    assign co2_forecast  = out_fc_reg[3];

endmodule

// ----- src/pollutant_window_alert_forecast_core.sv -----
`timescale 1ns / 1ps
// The back end sets the throughput: it handles one item at a time, reads and
// updates the window memory and runs sixteen steps on one shared multiplier.
// The front end computes the alert and weather scale alongside.
// Reset is asynchronous and active low; per-zone flags make all history read
// as zero at once, so no clearing pass is needed and items are taken at once.

module pollutant_window_alert_forecast_core #(
    parameter int HISTORY_DAYS = pwaf_pkg::HISTORY_DAYS_DEF,
    parameter int ZONE_COUNT   = pwaf_pkg::ZONE_COUNT_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // zone, pm25_sample, no2_sample, so2_sample, co2_sample, air_temperature,
    // wind_speed, relative_humidity
    input  logic [95:0]                        s_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // alert_level, pm25_forecast, no2_forecast, so2_forecast, co2_forecast
    output logic [63:0]                        m_tdata,
    input  logic                               cfg_we,
    input  logic [pwaf_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [pwaf_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import pwaf_pkg::*;

    cfg_t           cfg_reg;
    item_t          q_push_item, q_head_item;
    queue_status_t  q_status;
    logic           q_push, q_pop;
    logic [1:0]     alert_level;
    logic [12:0]    pm25_forecast, no2_forecast, so2_forecast;
    logic [FC_W-1:0] co2_forecast;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pm25_limit     <= PM25_LIMIT_RST;
            cfg_reg.no2_limit      <= NO2_LIMIT_RST;
            cfg_reg.so2_limit      <= SO2_LIMIT_RST;
            cfg_reg.co2_high_limit <= CO2_LIMIT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_PM25_LIMIT: cfg_reg.pm25_limit     <= cfg_data[12:0];
                REG_NO2_LIMIT:  cfg_reg.no2_limit      <= cfg_data[12:0];
                REG_SO2_LIMIT:  cfg_reg.so2_limit      <= cfg_data[12:0];
                REG_CO2_LIMIT:  cfg_reg.co2_high_limit <= cfg_data;
                default: ;
            endcase
        end
    end

    pwaf_front u_front (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg               (cfg_reg),
        .in_valid          (s_tvalid),
        .in_ready          (s_tready),
        .zone              (s_tdata[3:0]),
        .pm25_sample       (s_tdata[16:4]),
        .no2_sample        (s_tdata[29:17]),
        .so2_sample        (s_tdata[42:30]),
        .co2_sample        (s_tdata[58:43]),
        .air_temperature   (s_tdata[69:59]),
        .wind_speed        (s_tdata[80:70]),
        .relative_humidity (s_tdata[90:81]),
        .q_status          (q_status),
        .push              (q_push),
        .push_item         (q_push_item)
    );

    pwaf_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (q_push_item),
        .pop       (q_pop),
        .head_item (q_head_item),
        .status    (q_status)
    );

    pwaf_back #(
        .HISTORY_DAYS (HISTORY_DAYS),
        .ZONE_COUNT   (ZONE_COUNT)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_status      (q_status),
        .head_item     (q_head_item),
        .pop           (q_pop),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .alert_level   (alert_level),
        .pm25_forecast (pm25_forecast),
        .no2_forecast  (no2_forecast),
        .so2_forecast  (so2_forecast),
        .co2_forecast  (co2_forecast)
    );

    assign m_tdata = {6'd0, co2_forecast, so2_forecast, no2_forecast, pm25_forecast, alert_level};

    // The front end only pushes into the queue when it has room.
    assert property (@(posedge clk) disable iff (!rst_n) !(q_push && q_status.full))
        else $error("queue overflow");

    // The back end only pops an item that is there.
    assert property (@(posedge clk) disable iff (!rst_n) !(q_pop && q_status.empty))
        else $error("queue underflow");

    // The padding bits above the last field of a result beat stay zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[63:58] == 6'd0))
        else $error("output padding not zero");

endmodule

// ----- tb/pwaf_forecast_checker.sv -----
`timescale 1ns / 1ps

module pwaf_forecast_checker
    import pwaf_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [95:0]           s_tdata,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [63:0]           m_tdata,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    fail_count,
    output int                    pending_count
);

    localparam int DAYS  = HISTORY_DAYS_DEF;
    localparam int ZONES = ZONE_COUNT_DEF;
    localparam longint unsigned WEIGHT_TOTAL = DAYS * (DAYS + 1) / 2;

    typedef struct packed {
        logic [1:0]  level;
        logic [12:0] pm25;
        logic [12:0] no2;
        logic [12:0] so2;
        logic [16:0] co2;
    } forecast_t;

    cfg_t            limits;
    longint unsigned history [4][ZONES*DAYS];
    int unsigned     oldest_slot [ZONES];
    longint unsigned plain_sum [ZONES*4];
    longint unsigned weighted_sum [ZONES*4];
    forecast_t       forecast_queue [$];

    function automatic logic [1:0] rank(longint unsigned v, longint unsigned lim);
        if (lim == 0 || v <= lim)
            return 2'd0;
        if (2 * v <= 3 * lim)
            return 2'd1;
        if (v <= 2 * lim)
            return 2'd2;
        return 2'd3;
    endfunction

    function automatic longint unsigned scaled(longint unsigned wsum,
                                               longint unsigned factor,
                                               longint unsigned maxv);
        longint unsigned r;
        r = ((wsum / WEIGHT_TOTAL) * factor) >> 45;
        return (r > maxv) ? maxv : r;
    endfunction

    task automatic predict_alert_forecast(input logic [95:0] beat);
        logic [3:0]             zone;
        longint unsigned        smp [4];
        logic signed [10:0]     temp;
        longint unsigned        wind, hum, fw, fh, ft, factor, wt [4];
        logic [1:0]             lvl, t;
        int unsigned            head, k;
        forecast_t              f;
        zone   = beat[3:0];
        smp[0] = 64'(beat[16:4]);
        smp[1] = 64'(beat[29:17]);
        smp[2] = 64'(beat[42:30]);
        smp[3] = 64'(beat[58:43]);
        temp   = beat[69:59];
        wind   = 64'(beat[80:70]);
        hum    = 64'(beat[90:81]);
        lvl = rank(smp[0], limits.pm25_limit);
        t = rank(smp[1], limits.no2_limit);
        if (t > lvl) lvl = t;
        t = rank(smp[2], limits.so2_limit);
        if (t > lvl) lvl = t;
        if (smp[3] > limits.co2_high_limit && lvl == 2'd0) lvl = 2'd1;
        head = oldest_slot[zone];
        for (int p = 0; p < 4; p++)
        begin
            k = zone * 4 + p;
            weighted_sum[k] = weighted_sum[k] - plain_sum[k] + DAYS * smp[p];
            plain_sum[k] = plain_sum[k] - history[p][zone*DAYS+head] + smp[p];
            history[p][zone*DAYS+head] = smp[p];
            wt[p] = weighted_sum[k];
        end
        oldest_slot[zone] = (head + 1 >= DAYS) ? 0 : head + 1;
        if (wind > 1000) wind = 1000;
        if (hum > 1000) hum = 1000;
        fw = 32768 - (wind * 98304) / 10000;
        fh = 32768 + (hum * 491520) / 100000;
        if (temp < 100)
            ft = 39321;
        else if (temp > 200)
            ft = 29491;
        else
            ft = 32768;
        factor = fw * fh * ft;
        f.level = lvl;
        f.pm25  = 13'(scaled(wt[0], factor, 64'h1FFF));
        f.no2   = 13'(scaled(wt[1], factor, 64'h1FFF));
        f.so2   = 13'(scaled(wt[2], factor, 64'h1FFF));
        f.co2   = 17'(scaled(wt[3], factor, 64'h1FFFF));
        forecast_queue.push_back(f);
    endtask

    task automatic check_field(string name, longint unsigned want, longint unsigned got);
        if (want != got)
        begin
            fail_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    initial
    begin
        fail_count = 0;
        pending_count = 0;
        limits = '{PM25_LIMIT_RST, NO2_LIMIT_RST, SO2_LIMIT_RST, CO2_LIMIT_RST};
        foreach (history[p, i]) history[p][i] = 0;
        foreach (oldest_slot[z]) oldest_slot[z] = 0;
        foreach (plain_sum[k]) plain_sum[k] = 0;
        foreach (weighted_sum[k]) weighted_sum[k] = 0;
    end

    always @(posedge clk)
    begin
        forecast_t f;
        if (rst_n)
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_PM25_LIMIT: limits.pm25_limit = cfg_data[12:0];
                    REG_NO2_LIMIT:  limits.no2_limit = cfg_data[12:0];
                    REG_SO2_LIMIT:  limits.so2_limit = cfg_data[12:0];
                    REG_CO2_LIMIT:  limits.co2_high_limit = cfg_data;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                predict_alert_forecast(s_tdata);
            if (m_tvalid && m_tready)
            begin
                if (forecast_queue.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: unexpected result beat, expected none, actual %h",
                             $time, m_tdata);
                end
                else
                begin
                    f = forecast_queue.pop_front();
                    check_field("alert_level", f.level, m_tdata[1:0]);
                    check_field("pm25_forecast", f.pm25, m_tdata[14:2]);
                    check_field("no2_forecast", f.no2, m_tdata[27:15]);
                    check_field("so2_forecast", f.so2, m_tdata[40:28]);
                    check_field("co2_forecast", f.co2, m_tdata[57:41]);
                end
            end
            pending_count = forecast_queue.size();
        end
    end

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps

module tb;
    import pwaf_pkg::*;

    localparam int RANDOM_ITEMS = 1530;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [95:0]           s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [63:0]           m_tdata;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    fail_count;
    int                    pending_count;
    int                    send_idle_pct;
    int                    recv_idle_pct;

    pollutant_window_alert_forecast_core DUT (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    pwaf_forecast_checker checker_i (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .fail_count(fail_count), .pending_count(pending_count)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    always @(negedge clk)
        m_tready <= ($urandom_range(99) >= recv_idle_pct);

    initial
    begin
        #20ms;
        $display("tb: FAIL");
        $finish;
    end

    task automatic send_measurement(input logic [3:0] zone, input logic [12:0] pm25,
                                    input logic [12:0] no2, input logic [12:0] so2,
                                    input logic [15:0] co2, input logic [10:0] temp,
                                    input logic [10:0] wind, input logic [9:0] hum);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tdata = {5'd0, hum, wind, temp, co2, so2, no2, pm25, zone};
        s_tvalid = 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
        s_tvalid = 1'b0;
    endtask

    task automatic send_random_measurement();
        logic [12:0] pm25, no2, so2;
        logic [15:0] co2;
        logic [10:0] temp, wind;
        logic [9:0]  hum;
        if ($urandom_range(9) == 0)
        begin
            pm25 = 13'($urandom); no2 = 13'($urandom); so2 = 13'($urandom);
            co2 = 16'($urandom);
            temp = 11'($urandom); wind = 11'($urandom); hum = 10'($urandom);
        end
        else
        begin
            pm25 = 13'($urandom_range(5000));
            no2  = 13'($urandom_range(5000));
            so2  = 13'($urandom_range(5000));
            co2  = 16'($urandom_range(50000));
            temp = 11'($signed($urandom_range(1100)) - 500);
            wind = 11'($urandom_range(2000));
            hum  = 10'($urandom_range(1000));
        end
        send_measurement(($urandom_range(1) == 0) ? 4'($urandom_range(2)) : 4'($urandom),
                         pm25, no2, so2, co2, temp, wind, hum);
    endtask

    task automatic wait_drained();
        do
            @(posedge clk);
        while (pending_count != 0);
        repeat (40) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_limits(input logic [15:0] pm25, input logic [15:0] no2,
                                input logic [15:0] so2, input logic [15:0] co2);
        logic [15:0] vals [4];
        vals = '{pm25, no2, so2, co2};
        for (int i = 0; i < 4; i++)
        begin
            cfg_we = 1'b1;
            cfg_index = CFG_IDX_W'(i);
            cfg_data = vals[i];
            @(negedge clk);
        end
        cfg_we = 1'b0;
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_PM25_LIMIT;
        cfg_data = '0;
        send_idle_pct = 33;
        recv_idle_pct = 71;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        send_measurement(4'd0, 13'd0, 13'd0, 13'd0, 16'd0, 11'd0, 11'd0, 10'd0);
        send_measurement(4'd15, 13'd5000, 13'd5000, 13'd5000, 16'd50000,
                         11'd600, 11'd2000, 10'd1000);
        send_measurement(4'd15, 13'h1FFF, 13'h1FFF, 13'h1FFF, 16'hFFFF,
                         11'h3FF, 11'h7FF, 10'h3FF);
        send_measurement(4'd1, 13'd150, 13'd250, 13'd400, 16'd10000,
                         11'h600, 11'd1000, 10'd0);
        send_measurement(4'd1, 13'd151, 13'd0, 13'd0, 16'd0, 11'd99, 11'd999, 10'd999);
        send_measurement(4'd1, 13'd225, 13'd0, 13'd0, 16'd0, 11'd100, 11'd1001, 10'd1001);
        send_measurement(4'd1, 13'd226, 13'd0, 13'd0, 16'd0, 11'd200, 11'd500, 10'd500);
        send_measurement(4'd2, 13'd300, 13'd0, 13'd0, 16'd0, 11'd201, 11'd0, 10'd0);
        send_measurement(4'd2, 13'd301, 13'd0, 13'd0, 16'd0, 11'h60C, 11'd0, 10'd0);
        send_measurement(4'd2, 13'd0, 13'd376, 13'd0, 16'd0, 11'h7FF, 11'd0, 10'd0);
        send_measurement(4'd2, 13'd0, 13'd0, 13'd801, 16'd0, 11'h400, 11'd0, 10'd0);
        send_measurement(4'd3, 13'd10, 13'd10, 13'd10, 16'd10001, 11'd150, 11'd0, 10'd0);
        for (int i = 0; i < 8; i++)
            send_measurement(4'd4, 13'h1FFF, 13'h1FFF, 13'h1FFF, 16'hFFFF,
                             11'h600, 11'd0, 10'd1000);

        for (int phase = 0; phase < 4; phase++)
        begin
            if (phase > 0)
            begin
                wait_drained();
                case (phase)
                    1: write_limits(16'd0, 16'd0, 16'd0, 16'd0);
                    2: write_limits(16'h1FFF, 16'h1FFF, 16'h1FFF, 16'hFFFF);
                    default: write_limits(16'($urandom_range(5000)), 16'($urandom_range(5000)),
                                          16'($urandom_range(5000)),
                                          16'($urandom_range(50000)));
                endcase
            end
            for (int i = 0; i < RANDOM_ITEMS / 4; i++)
            begin
                case ((phase * (RANDOM_ITEMS / 4) + i) * 3 / RANDOM_ITEMS)
                    0: begin send_idle_pct = 33; recv_idle_pct = 71; end
                    1: begin send_idle_pct = 71; recv_idle_pct = 33; end
                    default: begin send_idle_pct = 0; recv_idle_pct = 0; end
                endcase
                send_random_measurement();
            end
        end

        wait_drained();
        if (fail_count == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule

// ----- pollutant_window_alert_forecast_core.f -----
src/pwaf_pkg.sv
src/pwaf_front.sv
src/pwaf_queue.sv
src/pwaf_back.sv
src/pollutant_window_alert_forecast_core.sv
tb/pwaf_forecast_checker.sv
tb/tb.sv
